### rtl/bounded_ordered_list_macros.svh
// Assertion macros for the bounded ordered list checker.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef BOUNDED_ORDERED_LIST_MACROS_SVH
`define BOUNDED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication.
`define BLO_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded_ordered_list: assertion failed");

// Next-cycle implication.
`define BLO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_ordered_list: assertion failed");

`endif

### rtl/blo_pkg.sv
// Package for the bounded ordered list: sizes, codes, request and response types,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package blo_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int CAP_W  = 5;

    localparam logic [2:0] CMD_ADD    = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_LOOKUP = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [1:0] RD_IDX  = 2'd0;
    localparam logic [1:0] RD_NEXT = 2'd1;
    localparam logic [1:0] RD_POS  = 2'd2;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [DATA_W-1:0] value;
        logic [3:0]        position;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic [CNT_W-1:0]  count;
        logic              is_full;
        logic              is_empty;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       wr_tail;
        logic       wr_shift;
        logic       idx_inc;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_hit;
        logic       out_rd;
    } blo_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       full;
        logic       pos_ok;
        logic       empty;
        logic       match;
        logic       last;
        logic       out_free;
    } blo_sts_t;

endpackage
`default_nettype wire

### rtl/blo_datapath.sv
// Datapath of the bounded ordered list: request register, entry memory, scan index,
// entry count, capacity register and response register. Uses blo_pkg.
`default_nettype none
module blo_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  blo_pkg::req_t          req_data,
    input  wire logic              cfg_valid,
    input  wire logic [blo_pkg::CAP_W-1:0] cfg_data,
    input  blo_pkg::blo_cmd_t      cmd,
    output blo_pkg::blo_sts_t      sts,
    output wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    output blo_pkg::rsp_t          rsp_data
);
    import blo_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    req_t              req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_valid_reg;
    rsp_t              out_reg;
    logic [CNT_W-1:0]  cap_eff;
    logic [IDX_W-1:0]  rd_addr, wr_addr;
    logic [CNT_W-1:0]  idx_plus;

    assign cap_eff  = (capacity_reg > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_reg);
    assign idx_plus = CNT_W'(idx_reg) + CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clr)
            count_next = '0;
        else if (cmd.cnt_inc)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_NEXT: rd_addr = idx_plus[IDX_W-1:0];
            RD_POS:  rd_addr = req_reg.position[IDX_W-1:0];
            default: rd_addr = idx_reg;
        endcase
        wr_addr = cmd.wr_tail ? count_reg[IDX_W-1:0] : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_tail)
            mem[wr_addr] <= req_reg.value;
        else if (cmd.wr_shift)
            mem[wr_addr] <= rd_data_reg;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.load)
            req_reg <= req_data;
        if (cmd.out_load)
        begin
            out_reg.status     <= cmd.out_status;
            out_reg.hit        <= cmd.out_hit;
            out_reg.read_value <= cmd.out_rd ? rd_data_reg : '0;
            out_reg.count      <= count_next;
            out_reg.is_full    <= (count_next >= cap_eff);
            out_reg.is_empty   <= (count_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            capacity_reg  <= CAP_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IDX_W'(1);
            count_reg <= count_next;
            if (cfg_valid)
                capacity_reg <= cfg_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.cmd      = req_reg.cmd;
    assign sts.full     = (count_reg >= cap_eff);
    assign sts.pos_ok   = (CNT_W'(req_reg.position) < count_reg);
    assign sts.empty    = (count_reg == '0);
    assign sts.match    = (rd_data_reg == req_reg.value);
    assign sts.last     = (idx_plus >= count_reg);
    assign sts.out_free = !out_valid_reg || !rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule
`default_nettype wire

### rtl/blo_controller.sv
// Controller state machine of the bounded ordered list: sequences add, scan,
// close-up, read and clear over the datapath. Uses blo_pkg.
`default_nettype none
module blo_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output wire logic          req_stall,
    input  blo_pkg::blo_sts_t  sts,
    output blo_pkg::blo_cmd_t  cmd
);
    import blo_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_READ     = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_SHIFT_RD = 3'd5;
    localparam logic [2:0] S_SHIFT_WR = 3'd6;

    logic [2:0] state_reg, state_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_IDX;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.cmd)
                    CMD_ADD:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            if (sts.full)
                                cmd.out_status = ST_FULL;
                            else
                            begin
                                cmd.wr_tail = 1'b1;
                                cmd.cnt_inc = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    CMD_REMOVE, CMD_LOOKUP:
                    begin
                        if (!sts.empty)
                            state_next = S_SCAN_RD;
                        else if (sts.out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_NOTFOUND;
                            state_next     = S_IDLE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (sts.pos_ok)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_READ;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.out_load   = 1'b1;
                            cmd.out_status = ST_RANGE;
                            state_next     = S_IDLE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.cnt_clr  = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = S_IDLE;
                        end
                    end
                endcase
            end
            S_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_rd   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.match)
                begin
                    if (sts.cmd == CMD_REMOVE)
                        state_next = S_SHIFT_RD;
                    else if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_hit  = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (sts.last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = ST_NOTFOUND;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.last)
                begin
                    if (sts.out_free)
                    begin
                        cmd.cnt_dec  = 1'b1;
                        cmd.out_load = 1'b1;
                        cmd.out_hit  = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list: controller plus datapath.
// Depends on blo_pkg, blo_controller and blo_datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  blo_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  blo_pkg::rsp_t
//   cfg      in         cfg_valid/cfg_ready  capacity, 5 bits
//
// One request at a time. An in-range read first reads the entry at its position.
// Lookup and remove scan the entries from entry 0 to the first match or the last entry;
// remove then closes the gap, reading each later entry and writing it one place down.
// Reset empties the list and sets capacity to 1.
// A stalled response holds the next finished result in its last state.
`default_nettype none
module bounded_ordered_list (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output wire logic                      req_stall,
    input  blo_pkg::req_t                  req_data,
    output wire logic                      rsp_valid,
    input  wire logic                      rsp_stall,
    output blo_pkg::rsp_t                  rsp_data,
    input  wire logic                      cfg_valid,
    output wire logic                      cfg_ready,
    input  wire logic [blo_pkg::CAP_W-1:0] cfg_data
);
    import blo_pkg::*;

    blo_cmd_t cmd;
    blo_sts_t sts;

    assign cfg_ready = 1'b1;

    blo_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    blo_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
`default_nettype wire

### rtl/blo_checker.sv
// Port-level checker for bounded_ordered_list, bound to the top level.
// Depends on blo_pkg and bounded_ordered_list_macros.svh.
`default_nettype none
`include "bounded_ordered_list_macros.svh"
module blo_checker (
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    req_valid,
    input wire logic    req_stall,
    input wire logic    rsp_valid,
    input wire logic    rsp_stall,
    input blo_pkg::rsp_t rsp_data
);
    import blo_pkg::*;

    `BLO_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
    `BLO_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
    `BLO_ASSERT_SAME(a_empty_flag, rsp_valid, rsp_data.is_empty == (rsp_data.count == '0))
    `BLO_ASSERT_SAME(a_hit_ok, rsp_valid && rsp_data.hit, rsp_data.status == ST_OK)
    `BLO_ASSERT_SAME(a_range_zero, rsp_valid && (rsp_data.status != ST_OK), rsp_data.read_value == '0)

endmodule

bind bounded_ordered_list blo_checker u_chk (.*);
`default_nettype wire
